FILE: rtl/oad_pkg.sv
// Package for the object identifier arc decoder.
// Holds the status codes, the result item type and the decode constants.
// Used by oid_arc_decoder, by its checker oad_chk and by the test bench; it depends on nothing else.
package oad_pkg;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_INCOMPLETE = 2'd1,
        STAT_OVERFLOW   = 2'd2
    } status_t;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        status_t     status;
    } result_t;

    localparam int          ARC_W      = 32;
    localparam int          GROUP_W    = 7;
    localparam logic [6:0]  GROUP_MASK = 7'h7F;
    localparam int          MORE_BIT   = 7;
    localparam logic [6:0]  ARC_SPLIT  = 7'd40;
    localparam logic [31:0] ARC_BASE2  = 32'd80;
    localparam logic [31:0] ARC_TOP    = 32'd2;

endpackage

FILE: rtl/oid_arc_decoder.sv
// Object identifier arc decoder: base-128 groups in, arc numbers out.
// Throughput: one byte per cycle while the result queue has room; a byte that ends the first
// subidentifier yields two results and waits in the input register until the two-entry queue has room for both.
// Reset (rst_n low, asynchronous) clears the accumulator and the flags and empties the input register and the queue.
// Depends on oad_pkg.
module oid_arc_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] arc_value
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // arc_last
);
    import oad_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       in_last_reg;

    // decode state
    logic [ARC_W-1:0] acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic             fad_reg, fad_next;

    // two-entry result queue, slot 0 is the head
    result_t     slot0_reg, slot0_next;
    result_t     slot1_reg, slot1_next;
    logic [1:0]  count_reg, count_next;

    logic [ARC_W-1:0] acc_cur;
    logic             ovf_cur;
    logic             fad_cur;
    logic [ARC_W-1:0] acc_shift;
    logic             ovf_shift;
    logic             small_first;
    logic             hi_arc;
    logic [6:0]       lo_arc;
    status_t          arc_status;
    result_t          res0;
    result_t          res1;
    logic [1:0]       res_n;
    logic             pop;
    logic [1:0]       remain;
    logic             fire;

    assign pop    = m_tvalid && m_tready;
    assign remain = count_reg - {1'b0, pop};

    // decode of the held item
    always_comb
    begin
        acc_cur     = in_first_reg ? '0   : acc_reg;
        ovf_cur     = in_first_reg ? 1'b0 : ovf_reg;
        fad_cur     = in_first_reg ? 1'b0 : fad_reg;
        ovf_shift   = ovf_cur || (acc_cur[ARC_W-1:ARC_W-GROUP_W] != '0);
        acc_shift   = {acc_cur[ARC_W-GROUP_W-1:0], in_byte_reg[GROUP_W-1:0] & GROUP_MASK};
        small_first = !ovf_shift && (acc_shift < ARC_BASE2);
        // v < 80 here, so one compare and subtract gives v/40 and v%40
        hi_arc      = (acc_shift[6:0] >= ARC_SPLIT);
        lo_arc      = hi_arc ? (acc_shift[6:0] - ARC_SPLIT) : acc_shift[6:0];
        arc_status  = ovf_shift ? STAT_OVERFLOW : STAT_OK;

        res0     = '{value: '0, last: 1'b0, status: STAT_OK};
        res1     = '{value: '0, last: 1'b0, status: STAT_OK};
        res_n    = 2'd0;
        acc_next = acc_cur;
        ovf_next = ovf_cur;
        fad_next = fad_cur;

        if (in_byte_reg[MORE_BIT])
        begin
            acc_next = acc_shift;
            ovf_next = ovf_shift;
            if (in_last_reg)
            begin
                res0  = '{value: '0, last: 1'b1, status: STAT_INCOMPLETE};
                res_n = 2'd1;
            end
        end
        else
        begin
            acc_next = '0;
            ovf_next = 1'b0;
            if (!fad_cur)
            begin
                fad_next = 1'b1;
                res_n    = 2'd2;
                if (small_first)
                begin
                    res0 = '{value: {31'd0, hi_arc}, last: 1'b0, status: STAT_OK};
                    res1 = '{value: {25'd0, lo_arc}, last: in_last_reg, status: STAT_OK};
                end
                else
                begin
                    res0 = '{value: ARC_TOP, last: 1'b0, status: STAT_OK};
                    res1 = '{value: acc_shift - ARC_BASE2, last: in_last_reg,
                             status: arc_status};
                end
            end
            else
            begin
                res0  = '{value: acc_shift, last: in_last_reg, status: arc_status};
                res_n = 2'd1;
            end
        end

        // end of identifier drops all state
        if (in_last_reg)
        begin
            acc_next = '0;
            ovf_next = 1'b0;
            fad_next = 1'b0;
        end
    end

    assign fire     = in_valid_reg && ({1'b0, remain} + {1'b0, res_n} <= 3'd2);
    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    end

    // queue update: drop the head on pop, then append new results
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = remain;
        if (pop)
        begin
            slot0_next = slot1_reg;
        end
        if (fire)
        begin
            count_next = remain + res_n;
            if (remain == 2'd0)
            begin
                slot0_next = res0;
                slot1_next = res1;
            end
            else if (remain == 2'd1)
            begin
                slot1_next = res0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            fad_reg      <= 1'b0;
            count_reg    <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            count_reg    <= count_next;
            if (fire)
            begin
                acc_reg <= acc_next;
                ovf_reg <= ovf_next;
                fad_reg <= fad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = slot0_reg.value;
    assign m_tlast  = slot0_reg.last;
    assign m_tuser  = slot0_reg.status;

endmodule

FILE: rtl/oad_chk.sv
// Port checker for oid_arc_decoder, attached by the bind statement below.
// Depends on oad_pkg and on the port list of oid_arc_decoder.
module oad_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,   // [31:0] arc_value
    input logic [1:0]  m_tuser,   // [1:0] status
    input logic        m_tlast    // arc_last
);
    import oad_pkg::*;

    // hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result item changed");

    // an incomplete encoding ends the identifier with a zero arc
    a_incomplete: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_INCOMPLETE) |-> m_tlast && (m_tdata == '0))
        else $error("incomplete status without zero arc and end mark");

    // with nothing queued the input side must take an item
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output queue is empty");

    // with nothing queued and nothing offered, the input side is free next cycle
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !s_tvalid |=> s_tready)
        else $error("input stalled after an idle cycle with an empty queue");

endmodule

bind oid_arc_decoder oad_chk u_oad_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: verif/oid_arc_decoder_test.sv
`timescale 1ns / 100ps
// Self-checking bench for oid_arc_decoder: OID content bytes in, arc numbers out.
// Uses a scoreboard class that predicts arcs per accepted byte; depends on oad_pkg.

import oad_pkg::*;

class arc_decode_board;
    logic [31:0] group_acc;
    bit          wide_seen;
    bit          split_done;
    result_t     arcs_due[$];
    int unsigned fails;

    function new();
        clear_id();
        fails = 0;
    endfunction

    function void clear_id();
        group_acc  = '0;
        wide_seen  = 1'b0;
        split_done = 1'b0;
    endfunction

    function void push_arc(logic [31:0] value, logic last, status_t st);
        result_t arc;
        arc.value  = value;
        arc.last   = last;
        arc.status = st;
        arcs_due.push_back(arc);
    endfunction

    // Work out the arcs that one accepted byte releases.
    function void note_byte(logic [7:0] data, bit first, bit last);
        logic [31:0] v;
        status_t     st;
        if (first)
            clear_id();
        if (group_acc[31:25] != '0)
            wide_seen = 1'b1;
        group_acc = {group_acc[24:0], data[6:0] & GROUP_MASK};
        if (data[MORE_BIT]) begin
            // continuation byte: nothing out unless the identifier ends here
            if (last) begin
                push_arc('0, 1'b1, STAT_INCOMPLETE);
                clear_id();
            end
            return;
        end
        v  = group_acc;
        st = wide_seen ? STAT_OVERFLOW : STAT_OK;
        if (!split_done) begin
            if (!wide_seen && v < ARC_BASE2) begin
                push_arc(v / ARC_SPLIT, 1'b0, STAT_OK);
                push_arc(v % ARC_SPLIT, last, STAT_OK);
            end
            else begin
                push_arc(ARC_TOP, 1'b0, STAT_OK);
                push_arc(v - ARC_BASE2, last, st);
            end
            split_done = 1'b1;
        end
        else begin
            push_arc(v, last, st);
        end
        group_acc = '0;
        wide_seen = 1'b0;
        if (last)
            clear_id();
    endfunction

    function void check_arc(logic [31:0] value, logic last, logic [1:0] status);
        result_t want;
        if (arcs_due.size() == 0) begin
            $error("unexpected arc: arc_value %0h arc_last %0b status %0d",
                   value, last, status);
            fails++;
            return;
        end
        want = arcs_due.pop_front();
        if (want.value !== value) begin
            $error("arc_value: expected %0h, actual %0h", want.value, value);
            fails++;
        end
        if (want.last !== last) begin
            $error("arc_last: expected %0b, actual %0b", want.last, last);
            fails++;
        end
        if (want.status !== status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fails++;
        end
    endfunction

    function int unsigned waiting();
        return arcs_due.size();
    endfunction
endclass

module oid_arc_decoder_test;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] byte_in
    logic        s_tuser = 1'b0;   // [0] first_byte
    logic        s_tlast = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] arc_value
    logic [1:0]  m_tuser;          // [1:0] status
    logic        m_tlast;          // arc_last

    arc_decode_board board;
    bit              quiet = 1'b0;
    int unsigned     bytes_sent = 0;
    int unsigned     hold_left = 0;

    oid_arc_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // Receiver back-pressure in bursts; no new bursts once the run goes quiet.
    always @(posedge clk)
    begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0) begin
            m_tready  <= 1'b0;
            hold_left <= $urandom_range(0, 18);
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_byte(s_tdata, s_tuser, s_tlast);
        if (rst_n && m_tvalid && m_tready)
            board.check_arc(m_tdata, m_tlast, m_tuser);
    end

    task automatic send_byte(input logic [7:0] data, input bit first, input bit last);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    // Hold the sender until every predicted arc has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (board.waiting() != 0);
    endtask

    // Encode one subidentifier base-128, with optional redundant leading groups.
    task automatic send_arc(input logic [63:0] v, input int pad, input bit first,
                            input bit last);
        int         groups;
        logic [6:0] g;
        groups = 1;
        while (groups < 10 && (v >> (7 * groups)) != 0)
            groups++;
        groups += pad;
        for (int i = groups - 1; i >= 0; i--) begin
            g = 7'((v >> (7 * i)) & 64'h7F);
            send_byte({i != 0, g}, first && i == groups - 1, last && i == 0);
        end
    endtask

    function automatic logic [63:0] random_arc();
        logic [63:0] v;
        case ($urandom_range(0, 11))
            0, 1, 2: v = 64'($urandom_range(0, 127));
            3, 4:    v = 64'($urandom_range(128, 16383));
            5:       v = 64'($urandom_range(0, 2**21 - 1));
            6, 7:    v = 64'($urandom_range(0, 2**28 - 1));
            8, 9:    v = 64'($urandom);
            10:      v = 64'hFFFF_FFFF - 64'($urandom_range(0, 3));
            default: v = {$urandom, $urandom} >> $urandom_range(24, 30);
        endcase
        return v;
    endfunction

    task automatic send_identifier();
        int          n_arcs;
        int          pad;
        bit          broken;
        logic [63:0] head;
        n_arcs = $urandom_range(0, 6);
        pad    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
        broken = ($urandom_range(0, 9) == 0);
        head   = $urandom_range(0, 1) ? 64'($urandom_range(0, 119)) : random_arc();
        send_arc(head, pad, $urandom_range(0, 3) != 0, n_arcs == 0 && !broken);
        for (int k = 0; k < n_arcs; k++)
            send_arc(random_arc(), pad, 1'b0, k == n_arcs - 1 && !broken);
        // truncated encoding: end on a byte that still says more follows
        if (broken) begin
            if ($urandom_range(0, 1))
                send_byte({1'b1, 7'($urandom_range(0, 127))}, 1'b0, 1'b0);
            send_byte({1'b1, 7'($urandom_range(0, 127))}, 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1.2.840.113549
        send_byte(8'h2A, 1'b1, 1'b0);
        send_byte(8'h86, 1'b0, 1'b0);
        send_byte(8'h48, 1'b0, 1'b0);
        send_byte(8'h86, 1'b0, 1'b0);
        send_byte(8'hF7, 1'b0, 1'b0);
        send_byte(8'h0D, 1'b0, 1'b1);
        // largest single-byte head, then the split boundary at 80
        send_byte(8'h7F, 1'b1, 1'b1);
        send_byte(8'h50, 1'b1, 1'b1);
        // multi-byte head with no first flag: prior end already cleared state
        send_byte(8'h88, 1'b0, 1'b0);
        send_byte(8'h37, 1'b0, 1'b1);
        // head of exactly 2^32: overflow on the first subidentifier
        send_byte(8'h90, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // padded arc, overflow on a later arc, then an incomplete end
        send_byte(8'h2B, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        wait_drained();

        while (bytes_sent < 1800) begin
            if (bytes_sent >= 1600)
                quiet = 1'b1;
            case ($urandom_range(0, 19))
                0: begin
                    repeat ($urandom_range(1, 8))
                        send_byte(8'($urandom), $urandom_range(0, 3) == 0,
                                  $urandom_range(0, 3) == 0);
                end
                1: wait_drained();
                default: send_identifier();
            endcase
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.fails == 0 && board.waiting() == 0)
            $display("oid_arc_decoder_test OK");
        else
            $display("oid_arc_decoder_test NOT OK");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("oid_arc_decoder_test NOT OK");
        $finish;
    end

endmodule
